FILE: design/rhls_pkg.sv
// ----------------------------------------------------------------------------
// rhls_pkg: shared types and constants for the L1-norm RGB to HLS pipeline
// Widths of the pipeline's datapath, the sector codes and the side-band
// record that travels alongside the hue division.
// ----------------------------------------------------------------------------
package rhls_pkg;

   localparam int PIX_W    = 8;
   localparam int SUM_W    = 10;  // r+g+b, up to 765
   localparam int LNUM_W   = 11;  // 2*sum+3, up to 1533
   localparam int N_W      = 10;  // max+min-2*mid, signed
   localparam int X_W      = 9;   // twice the saturation, 0..510
   localparam int SECTOR_W = 3;
   localparam int PPROD_W  = SECTOR_W + 1 + X_W;  // (2*sector+1)*x
   localparam int A_W      = 14;  // signed hue numerator before the 85 scale
   localparam int DVD_W    = 20;  // 85*a + 2*x, below 2^19
   localparam int DVS_W    = X_W + 2;  // 4*x
   localparam int QUOT_W   = 9;   // top bit flags a quotient above 255

   // floor(v/6) for v < 1536 as (v*43691) >> 18
   localparam int                    LIGHT_SHIFT = 18;
   localparam logic [15:0]           LIGHT_RECIP = 16'd43691;
   localparam int                    LPROD_W     = LNUM_W + 16;
   localparam logic [DVD_W-1:0]      HUE_SCALE   = 20'd85;

   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES   = QUOT_W;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES;

   typedef logic [SECTOR_W-1:0] sector_type;

   // channel order, first match wins
   localparam sector_type SECTOR_RGB = 3'd0;  // r >= g >= b
   localparam sector_type SECTOR_GRB = 3'd1;  // g >= r >= b
   localparam sector_type SECTOR_GBR = 3'd2;  // g >= b >= r
   localparam sector_type SECTOR_BGR = 3'd3;  // b >= g >= r
   localparam sector_type SECTOR_BRG = 3'd4;  // b >= r >= g
   localparam sector_type SECTOR_RBG = 3'd5;  // r >= b >= g

   typedef struct packed {
      logic [PIX_W-1:0] light;
      logic [PIX_W-1:0] sat;
      logic             grey;
   } side_type;

endpackage

FILE: design/rgb_to_hls_l1_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hls_l1_pixel: RGB to L1-norm HLS conversion, one pixel per clock
// Channel   Ports                               Transfer
// request   start, busy, req_red/green/blue     edge with start high, busy low
// result    rsp_strobe, rsp_hue/lightness/sat   edge ending the strobe cycle
//
// One pixel enters per clock while busy is low; each result passes one
// ordering stage, three operand stages and nine divider stages, one
// quotient bit each. busy is high only in the cycle after reset; reset
// empties the pipeline. Results cannot be held off, so nothing ever stalls.
// ----------------------------------------------------------------------------
module rgb_to_hls_l1_pixel (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_strobe,
   output logic [7:0] rsp_hue,
   output logic [7:0] rsp_lightness,
   output logic [7:0] rsp_saturation
);
   import rhls_pkg::*;

   logic             busy_in, busy_ff;
   logic             accept;

   logic             ord_valid;
   sector_type       ord_sector;
   logic [PIX_W-1:0] ord_hi, ord_mid, ord_lo;
   logic [SUM_W-1:0] ord_sum;

   logic             fr_valid;
   logic [DVD_W-1:0] fr_dividend;
   logic [DVS_W-1:0] fr_divisor;
   side_type         fr_side;

   logic              dv_valid;
   logic [QUOT_W-1:0] dv_quot;
   side_type          dv_side;

   assign busy_in = reset;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   rhls_order u_order (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (ord_valid),
      .sector    (ord_sector),
      .hi        (ord_hi),
      .mid       (ord_mid),
      .lo        (ord_lo),
      .sum       (ord_sum)
   );

   rhls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ord_valid),
      .sector    (ord_sector),
      .hi        (ord_hi),
      .mid       (ord_mid),
      .lo        (ord_lo),
      .sum       (ord_sum),
      .out_valid (fr_valid),
      .dividend  (fr_dividend),
      .divisor   (fr_divisor),
      .side      (fr_side)
   );

   rhls_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .dividend  (fr_dividend),
      .divisor   (fr_divisor),
      .side_in   (fr_side),
      .out_valid (dv_valid),
      .quotient  (dv_quot),
      .side_out  (dv_side)
   );

   always_comb begin
      if (dv_side.grey) begin
         rsp_hue = '0;
      end else if (dv_quot[QUOT_W-1]) begin
         rsp_hue = '1;
      end else begin
         rsp_hue = dv_quot[PIX_W-1:0];
      end
   end

   assign rsp_strobe     = dv_valid;
   assign rsp_lightness  = dv_side.light;
   assign rsp_saturation = dv_side.sat;

endmodule

FILE: design/rhls_order.sv
// ----------------------------------------------------------------------------
// rhls_order: channel ordering stage
// Finds the sector from the channel order and registers max, mid, min and
// the channel sum.
// ----------------------------------------------------------------------------
module rhls_order (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [7:0]               red,
   input  logic [7:0]               green,
   input  logic [7:0]               blue,
   output logic                     out_valid,
   output rhls_pkg::sector_type     sector,
   output logic [7:0]               hi,
   output logic [7:0]               mid,
   output logic [7:0]               lo,
   output logic [rhls_pkg::SUM_W-1:0] sum
);
   import rhls_pkg::*;

   logic ge_rg, ge_gr, ge_gb, ge_bg, ge_rb, ge_br;
   sector_type       sector_in, sector_ff;
   logic [PIX_W-1:0] hi_in, mid_in, lo_in;
   logic [PIX_W-1:0] hi_ff, mid_ff, lo_ff;
   logic [SUM_W-1:0] sum_in, sum_ff;
   logic             valid_ff;

   assign ge_rg = red >= green;
   assign ge_gr = green >= red;
   assign ge_gb = green >= blue;
   assign ge_bg = blue >= green;
   assign ge_rb = red >= blue;
   assign ge_br = blue >= red;

   assign sum_in = {2'b00, red} + {2'b00, green} + {2'b00, blue};

   always_comb begin
      if (ge_rg && ge_gb) begin
         sector_in = SECTOR_RGB;
      end else if (ge_gr && ge_rb) begin
         sector_in = SECTOR_GRB;
      end else if (ge_gb && ge_br) begin
         sector_in = SECTOR_GBR;
      end else if (ge_bg && ge_gr) begin
         sector_in = SECTOR_BGR;
      end else if (ge_br && ge_rg) begin
         sector_in = SECTOR_BRG;
      end else begin
         sector_in = SECTOR_RBG;
      end

      case (sector_in)
         SECTOR_RGB: begin hi_in = red;   mid_in = green; lo_in = blue;  end
         SECTOR_GRB: begin hi_in = green; mid_in = red;   lo_in = blue;  end
         SECTOR_GBR: begin hi_in = green; mid_in = blue;  lo_in = red;   end
         SECTOR_BGR: begin hi_in = blue;  mid_in = green; lo_in = red;   end
         SECTOR_BRG: begin hi_in = blue;  mid_in = red;   lo_in = green; end
         default:    begin hi_in = red;   mid_in = blue;  lo_in = green; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff <= sector_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      lo_ff     <= lo_in;
      sum_ff    <= sum_in;
   end

   assign out_valid = valid_ff;
   assign sector    = sector_ff;
   assign hi        = hi_ff;
   assign mid       = mid_ff;
   assign lo        = lo_ff;
   assign sum       = sum_ff;

endmodule

FILE: design/rhls_front.sv
// ----------------------------------------------------------------------------
// rhls_front: saturation, lightness and hue operand stages
// Three register stages: offset n and doubled saturation x with the
// lightness; the signed hue numerator with saturation; the divider operands.
// ----------------------------------------------------------------------------
module rhls_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rhls_pkg::sector_type       sector,
   input  logic [7:0]                 hi,
   input  logic [7:0]                 mid,
   input  logic [7:0]                 lo,
   input  logic [rhls_pkg::SUM_W-1:0] sum,
   output logic                       out_valid,
   output logic [rhls_pkg::DVD_W-1:0] dividend,
   output logic [rhls_pkg::DVS_W-1:0] divisor,
   output rhls_pkg::side_type         side
);
   import rhls_pkg::*;

   // stage 2
   logic signed [N_W-1:0] n_in, n_ff;
   logic [N_W-1:0]        x_wide;
   logic [X_W-1:0]        x_in, x2_ff;
   logic [LNUM_W-1:0]     lnum;
   logic [LPROD_W-1:0]    lprod;
   logic [PIX_W-1:0]      light_in, light_ff;
   sector_type            sector2_ff;
   logic                  valid2_ff;

   // stage 3
   logic [PPROD_W-1:0]    pprod;
   logic signed [A_W-1:0] n_twice, a_in, a_ff;
   logic [X_W:0]          sat_wide;
   side_type              side3_in, side3_ff;
   logic [X_W-1:0]        x3_ff;
   logic                  valid3_ff;

   // stage 4
   logic [DVD_W-1:0]      p85, twox, dvd_in, dvd_ff;
   logic [DVS_W-1:0]      dvs_in, dvs_ff;
   side_type              side4_ff;
   logic                  valid4_ff;

   // ---- stage 2 ----
   assign n_in = $signed({2'b00, hi}) + $signed({2'b00, lo}) - $signed({1'b0, mid, 1'b0});

   always_comb begin
      if (!n_in[N_W-1]) begin
         x_wide = {1'b0, hi, 1'b0} - {2'b00, mid} - {2'b00, lo};
      end else begin
         x_wide = {2'b00, hi} + {2'b00, mid} - {1'b0, lo, 1'b0};
      end
   end
   assign x_in = x_wide[X_W-1:0];

   assign lnum     = {sum, 1'b0} + LNUM_W'(3);
   assign lprod    = {16'b0, lnum} * {{LNUM_W{1'b0}}, LIGHT_RECIP};
   assign light_in = lprod[LIGHT_SHIFT +: PIX_W];

   // ---- stage 3 ----
   assign pprod   = {{X_W{1'b0}}, sector2_ff, 1'b1} * {{(SECTOR_W + 1){1'b0}}, x2_ff};
   assign n_twice = {{(A_W - N_W - 1){n_ff[N_W-1]}}, n_ff, 1'b0};

   always_comb begin
      // even sectors subtract the offset, odd sectors add it
      if (sector2_ff[0]) begin
         a_in = $signed({1'b0, pprod}) + n_twice;
      end else begin
         a_in = $signed({1'b0, pprod}) - n_twice;
      end
   end

   assign sat_wide       = {1'b0, x2_ff} + (X_W + 1)'(1);
   assign side3_in.light = light_ff;
   assign side3_in.sat   = sat_wide[PIX_W:1];
   assign side3_in.grey  = (x2_ff == '0);

   // ---- stage 4 ----
   // a negative numerator clamps the scaled value to zero, leaving the rounding term
   assign p85    = {{(DVD_W - A_W + 1){1'b0}}, a_ff[A_W-2:0]} * HUE_SCALE;
   assign twox   = {{(DVD_W - X_W - 1){1'b0}}, x3_ff, 1'b0};
   assign dvd_in = a_ff[A_W-1] ? twox : p85 + twox;
   assign dvs_in = {x3_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid2_ff <= in_valid;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      x2_ff      <= x_in;
      light_ff   <= light_in;
      sector2_ff <= sector;

      a_ff       <= a_in;
      x3_ff      <= x2_ff;
      side3_ff   <= side3_in;

      dvd_ff     <= dvd_in;
      dvs_ff     <= dvs_in;
      side4_ff   <= side3_ff;
   end

   assign out_valid = valid4_ff;
   assign dividend  = dvd_ff;
   assign divisor   = dvs_ff;
   assign side      = side4_ff;

endmodule

FILE: design/rhls_div.sv
// ----------------------------------------------------------------------------
// rhls_div: pipelined restoring divider for the hue quotient
// One quotient bit per stage, most significant first. The top bit only
// tells whether the quotient exceeds the 8-bit range.
// ----------------------------------------------------------------------------
module rhls_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [rhls_pkg::DVD_W-1:0]  dividend,
   input  logic [rhls_pkg::DVS_W-1:0]  divisor,
   input  rhls_pkg::side_type          side_in,
   output logic                        out_valid,
   output logic [rhls_pkg::QUOT_W-1:0] quotient,
   output rhls_pkg::side_type          side_out
);
   import rhls_pkg::*;

   logic [DVD_W-1:0]  rem_src  [0:DIV_STAGES-1];
   logic [DVS_W-1:0]  dvs_src  [0:DIV_STAGES-1];
   logic [QUOT_W-1:0] quot_src [0:DIV_STAGES];
   side_type          side_src [0:DIV_STAGES];
   logic              vld_src  [0:DIV_STAGES];

   logic [DVD_W-1:0]  rem_ff   [0:DIV_STAGES-2];
   logic [DVS_W-1:0]  dvs_ff   [0:DIV_STAGES-2];
   logic [QUOT_W-1:0] quot_ff  [0:DIV_STAGES-1];
   side_type          side_ff  [0:DIV_STAGES-1];
   logic              valid_ff [0:DIV_STAGES-1];

   assign rem_src[0]  = dividend;
   assign dvs_src[0]  = divisor;
   assign quot_src[0] = '0;
   assign side_src[0] = side_in;
   assign vld_src[0]  = in_valid;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      localparam int SH = DIV_STAGES - 1 - k;
      logic [DVD_W-1:0] trial;
      logic             take;

      assign trial = DVD_W'(dvs_src[k]) << SH;
      assign take  = rem_src[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= vld_src[k];
         end
      end

      always_ff @(posedge clock) begin
         quot_ff[k] <= {quot_src[k][QUOT_W-2:0], take};
         side_ff[k] <= side_src[k];
      end

      assign quot_src[k+1] = quot_ff[k];
      assign side_src[k+1] = side_ff[k];
      assign vld_src[k+1]  = valid_ff[k];

      if (k < DIV_STAGES - 1) begin : g_fwd
         always_ff @(posedge clock) begin
            rem_ff[k] <= take ? rem_src[k] - trial : rem_src[k];
            dvs_ff[k] <= dvs_src[k];
         end
         assign rem_src[k+1] = rem_ff[k];
         assign dvs_src[k+1] = dvs_ff[k];
      end
   end

   assign out_valid = vld_src[DIV_STAGES];
   assign quotient  = quot_src[DIV_STAGES];
   assign side_out  = side_src[DIV_STAGES];

endmodule

FILE: design/rhls_checker.sv
// ----------------------------------------------------------------------------
// rhls_checker: port-level checks for rgb_to_hls_l1_pixel
// Fixed latency in both directions, grey pixel results, busy only after reset.
// ----------------------------------------------------------------------------
module rhls_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic [7:0] req_red,
   input logic [7:0] req_green,
   input logic [7:0] req_blue,
   input logic       rsp_strobe,
   input logic [7:0] rsp_hue,
   input logic [7:0] rsp_lightness,
   input logic [7:0] rsp_saturation
);
   import rhls_pkg::*;

   // every transfer is followed by its result on the strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result missing after request transfer");

   // no result without a matching transfer
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without request transfer");

   // grey pixel: no hue, no saturation, lightness equals the channel
   a_grey: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_red == req_green && req_green == req_blue)
      |-> ##LATENCY (rsp_hue == 8'd0 && rsp_saturation == 8'd0
                     && rsp_lightness == $past(req_red, LATENCY)))
      else $error("grey pixel converted wrongly");

   // busy rises in the cycle after reset and never rises otherwise
   a_busy: assert property (@(posedge clock)
      $rose(busy) |-> $past(reset))
      else $error("busy raised outside reset");

endmodule

bind rgb_to_hls_l1_pixel rhls_checker u_rhls_checker (.*);

FILE: sim/tb_rgb_to_hls_l1_pixel.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hls_l1_pixel: self-checking bench for the L1-norm HLS converter
// Pixels are pushed through the start/busy port. Directed corner cases come
// first, then random pixels with idle bursts, tie-heavy pixels, a drain pause
// and a back-to-back stream. Every result on the strobe is compared against
// an integer predictor of hue, lightness and saturation.
// ----------------------------------------------------------------------------
module tb_rgb_to_hls_l1_pixel;
   timeunit 1ns;
   timeprecision 1ps;

   import rhls_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] light;
      logic [7:0] sat;
   } hls_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   logic [7:0] req_red;
   logic [7:0] req_green;
   logic [7:0] req_blue;
   logic       rsp_strobe;
   logic [7:0] rsp_hue;
   logic [7:0] rsp_lightness;
   logic [7:0] rsp_saturation;

   hls_type expected_hls[$];
   hls_type want_hls;
   int      pixels_sent    = 0;
   int      results_seen   = 0;
   int      mismatch_count = 0;
   int      stall_cycles   = 0;

   rgb_to_hls_l1_pixel i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_strobe     (rsp_strobe),
      .rsp_hue        (rsp_hue),
      .rsp_lightness  (rsp_lightness),
      .rsp_saturation (rsp_saturation)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic sector_type order_sector(int r, int g, int b);
      if (r >= g && g >= b) return SECTOR_RGB;
      if (g >= r && r >= b) return SECTOR_GRB;
      if (g >= b && b >= r) return SECTOR_GBR;
      if (b >= g && g >= r) return SECTOR_BGR;
      if (b >= r && r >= g) return SECTOR_BRG;
      return SECTOR_RBG;
   endfunction

   // exact rational hue: 85*((2s+1)*x -/+ 2n) / (4x), rounded half up
   function automatic hls_type convert_pixel(logic [7:0] red, logic [7:0] green,
                                             logic [7:0] blue);
      hls_type    res;
      int         r, g, b, hi, lo, total, mid, dev, x2, lt, st, hv, num, den;
      sector_type sec;
      r = red;
      g = green;
      b = blue;
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      total = r + g + b;
      mid = total - hi - lo;
      lt = (2 * total + 3) / 6;
      if (lt > 255) lt = 255;
      dev = hi + lo - 2 * mid;
      x2 = (dev >= 0) ? (2 * hi - mid - lo) : (hi + mid - 2 * lo);
      st = (x2 + 1) / 2;
      if (st > 255) st = 255;
      if (x2 == 0) begin
         hv = 0;
      end else begin
         sec = order_sector(r, g, b);
         if (sec[0] == 1'b0)
            num = 85 * ((2 * int'(sec) + 1) * x2 - 2 * dev);
         else
            num = 85 * ((2 * int'(sec) + 1) * x2 + 2 * dev);
         den = 4 * x2;
         if (num < 0) num = 0;
         hv = (2 * num + den) / (2 * den);
         if (hv > 255) hv = 255;
      end
      res.hue   = hv[7:0];
      res.light = lt[7:0];
      res.sat   = st[7:0];
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   // one pixel transfer; start is left high so the next pixel can follow
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_hls.push_back(convert_pixel(r, g, b));
      pixels_sent++;
   endtask

   task automatic maybe_idle(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (expected_hls.size() != 0) @(posedge clock);
   endtask

   task automatic test_corners();
      send_pixel(8'd0,   8'd0,   8'd0);     // grey black
      send_pixel(8'd255, 8'd255, 8'd255);   // grey white
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);     // ties between top channels
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd200, 8'd100, 8'd0);     // mid exactly halfway
      send_pixel(8'd200, 8'd150, 8'd10);    // one per sector, strict order
      send_pixel(8'd150, 8'd200, 8'd10);
      send_pixel(8'd10,  8'd200, 8'd150);
      send_pixel(8'd10,  8'd150, 8'd200);
      send_pixel(8'd150, 8'd10,  8'd200);
      send_pixel(8'd200, 8'd10,  8'd150);
      send_pixel(8'd1,   8'd0,   8'd0);     // smallest nonzero saturation
      send_pixel(8'd254, 8'd255, 8'd255);
      send_pixel(8'd100, 8'd100, 8'd0);     // ties at the top and at the low end
      send_pixel(8'd0,   8'd100, 8'd0);
      send_pixel(8'd170, 8'd85,  8'd85);
      maybe_idle(100);
   endtask

   task automatic test_random_idle(input int count);
      repeat (count) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         maybe_idle(30);
      end
   endtask

   // each channel is one of two shared values or a fresh random one, so ties and greys are common
   task automatic test_ties(input int count);
      logic [7:0] va, vb, ch[3];
      repeat (count) begin
         va = 8'($urandom);
         vb = ($urandom_range(0, 1) != 0) ? 8'($urandom)
                                           : 8'(va + $urandom_range(0, 4) - 2);
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 2))
               0:       ch[k] = va;
               1:       ch[k] = vb;
               default: ch[k] = 8'($urandom);
            endcase
         end
         send_pixel(ch[0], ch[1], ch[2]);
         maybe_idle(20);
      end
   endtask

   task automatic test_drain_pause(input int count);
      repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      drain_results();
      repeat (count) begin
         send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
         maybe_idle(15);
      end
   endtask

   task automatic test_stream(input int count);
      repeat (count) send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      start <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_hls.size() == 0) begin
            note_mismatch($sformatf("unexpected result hue=%0d light=%0d sat=%0d",
                                    rsp_hue, rsp_lightness, rsp_saturation));
         end else begin
            want_hls = expected_hls.pop_front();
            if (rsp_hue !== want_hls.hue || rsp_lightness !== want_hls.light ||
                rsp_saturation !== want_hls.sat)
               note_mismatch($sformatf(
                  "hue exp %0d got %0d, light exp %0d got %0d, sat exp %0d got %0d",
                  want_hls.hue, rsp_hue, want_hls.light, rsp_lightness,
                  want_hls.sat, rsp_saturation));
         end
      end
   end

   // counts cycles without any transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("tb_rgb_to_hls_l1_pixel failed");
            $finish;
         end
      end
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_red   <= 8'd0;
      req_green <= 8'd0;
      req_blue  <= 8'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_corners();
      test_random_idle(550);
      test_ties(250);
      test_drain_pause(30);
      test_stream(290);

      drain_results();
      repeat (LATENCY + 4) @(posedge clock);
      if (expected_hls.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", expected_hls.size()));

      $display("%0d pixels sent, %0d results checked: corners, all six sectors,",
               pixels_sent, results_seen);
      $display("ties and greys, idle bursts, a full drain pause and a back-to-back run");
      if (mismatch_count == 0) begin
         $display("tb_rgb_to_hls_l1_pixel passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("tb_rgb_to_hls_l1_pixel failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/rhls_pkg.sv
design/rhls_order.sv
design/rhls_front.sv
design/rhls_div.sv
design/rgb_to_hls_l1_pixel.sv
design/rhls_checker.sv
sim/tb_rgb_to_hls_l1_pixel.sv
